@@ hdl/mwsm_pkg.sv @@
package mwsm_pkg;

   localparam int COEF_FRAC_BITS_DEF = 8;

   localparam int CMD_W      = 16;
   localparam int LIM_W      = 15;
   localparam int RATIO_W    = 16;
   localparam int OUT_W      = 16;
   localparam int NUM_WHEELS = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [LIM_W-1:0]   SIDEWAYS_LIMIT_RST = LIM_W'(500);
   localparam logic [LIM_W-1:0]   FORWARD_LIMIT_RST  = LIM_W'(500);
   localparam logic [LIM_W-1:0]   TURN_LIMIT_RST     = LIM_W'(200);
   localparam logic [RATIO_W-1:0] FRONT_RATIO_RST    = RATIO_W'(1117);
   localparam logic [RATIO_W-1:0] BACK_RATIO_RST     = RATIO_W'(1117);
   localparam logic [RATIO_W-1:0] RPM_RATIO_RST      = RATIO_W'(7276);
   localparam logic [LIM_W-1:0]   RPM_LIMIT_RST      = LIM_W'(15000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIDEWAYS_LIMIT = 3'd0,
      CSR_FORWARD_LIMIT  = 3'd1,
      CSR_TURN_LIMIT     = 3'd2,
      CSR_FRONT_RATIO    = 3'd3,
      CSR_BACK_RATIO     = 3'd4,
      CSR_RPM_RATIO      = 3'd5,
      CSR_RPM_LIMIT      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [NUM_WHEELS-1:0] neg;
      logic                  scaled;
   } side_type;

   // width of one exact wheel sum in q.f
   function automatic int sum_width(input int f);
      int mix_w;
      int turn_w;
      mix_w  = CMD_W + 1 + f;
      turn_w = CMD_W + RATIO_W + 1;
      return ((mix_w > turn_w) ? mix_w : turn_w) + 1;
   endfunction

   // width of one wheel rpm magnitude before limiting
   function automatic int rpm_width(input int f);
      return sum_width(f) + RATIO_W - 2 * f;
   endfunction

endpackage

@@ hdl/mecanum_wheel_speed_mixer_core.sv @@
// mecanum wheel speed mixer core
// throughput: one request per cycle, stalls only when the output register is held
// and every stage ahead of it is full
// depth set by 6 mixing stages (clamp, turn multiply, sum, rpm multiply, max, scale
// multiply), a 15-stage restoring divider (one quotient bit per stage) and the output register
// reset: synchronous, active high; clears all valids and loads register defaults
module mecanum_wheel_speed_mixer_core import mwsm_pkg::*; #(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [CMD_W-1:0] req_sideways_speed,
   input  logic signed [CMD_W-1:0] req_forward_speed,
   input  logic signed [CMD_W-1:0] req_turn_rate,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [OUT_W-1:0] rsp_wheel0_rpm,
   output logic signed [OUT_W-1:0] rsp_wheel1_rpm,
   output logic signed [OUT_W-1:0] rsp_wheel2_rpm,
   output logic signed [OUT_W-1:0] rsp_wheel3_rpm,
   output logic                    rsp_was_scaled,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int MIX_W  = CMD_W + 1;
   localparam int TURN_W = CMD_W + RATIO_W + 1;
   localparam int SUM_W  = sum_width(COEF_FRAC_BITS);
   localparam int PROD_W = SUM_W + RATIO_W;
   localparam int RPM_W  = rpm_width(COEF_FRAC_BITS);
   localparam int N_W    = RPM_W + LIM_W;

   function automatic logic signed [CMD_W-1:0] clamp_cmd(
      input logic signed [CMD_W-1:0] v,
      input logic [LIM_W-1:0]        lim
   );
      logic signed [CMD_W:0] v_x;
      logic signed [CMD_W:0] hi;
      logic signed [CMD_W:0] lo;
      v_x = (CMD_W+1)'(v);
      hi  = $signed({{(CMD_W+1-LIM_W){1'b0}}, lim});
      lo  = -hi;
      if (v_x > hi) begin
         return hi[CMD_W-1:0];
      end else if (v_x < lo) begin
         return lo[CMD_W-1:0];
      end
      return v;
   endfunction

   // configuration registers
   logic [LIM_W-1:0]   side_lim_ff;
   logic [LIM_W-1:0]   fwd_lim_ff;
   logic [LIM_W-1:0]   turn_lim_ff;
   logic [RATIO_W-1:0] front_ratio_ff;
   logic [RATIO_W-1:0] back_ratio_ff;
   logic [RATIO_W-1:0] rpm_ratio_ff;
   logic [LIM_W-1:0]   rpm_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_lim_ff    <= SIDEWAYS_LIMIT_RST;
         fwd_lim_ff     <= FORWARD_LIMIT_RST;
         turn_lim_ff    <= TURN_LIMIT_RST;
         front_ratio_ff <= FRONT_RATIO_RST;
         back_ratio_ff  <= BACK_RATIO_RST;
         rpm_ratio_ff   <= RPM_RATIO_RST;
         rpm_lim_ff     <= RPM_LIMIT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SIDEWAYS_LIMIT: side_lim_ff    <= csr_wdata[LIM_W-1:0];
            CSR_FORWARD_LIMIT:  fwd_lim_ff     <= csr_wdata[LIM_W-1:0];
            CSR_TURN_LIMIT:     turn_lim_ff    <= csr_wdata[LIM_W-1:0];
            CSR_FRONT_RATIO:    front_ratio_ff <= csr_wdata[RATIO_W-1:0];
            CSR_BACK_RATIO:     back_ratio_ff  <= csr_wdata[RATIO_W-1:0];
            CSR_RPM_RATIO:      rpm_ratio_ff   <= csr_wdata[RATIO_W-1:0];
            CSR_RPM_LIMIT:      rpm_lim_ff     <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline registers
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;
   logic div_ready;

   logic signed [CMD_W-1:0]  x1_ff, y1_ff, w1_ff;
   logic signed [CMD_W-1:0]  x1_in, y1_in, w1_in;
   logic signed [MIX_W-1:0]  a2_ff, b2_ff, a2_in, b2_in;
   logic signed [TURN_W-1:0] tf2_ff, tb2_ff, tf2_in, tb2_in;

   logic signed [MIX_W-1:0]  mix3 [NUM_WHEELS];
   logic signed [TURN_W-1:0] turn3 [NUM_WHEELS];
   logic signed [SUM_W-1:0]  s3 [NUM_WHEELS];
   logic [NUM_WHEELS-1:0]    neg3_ff, neg3_in;
   logic [SUM_W-1:0]         mag3_ff [NUM_WHEELS];
   logic [SUM_W-1:0]         mag3_in [NUM_WHEELS];

   logic [PROD_W-1:0]        prod4 [NUM_WHEELS];
   logic [NUM_WHEELS-1:0]    neg4_ff;
   logic [RPM_W-1:0]         rpm4_ff [NUM_WHEELS];
   logic [RPM_W-1:0]         rpm4_in [NUM_WHEELS];

   logic [NUM_WHEELS-1:0]    neg5_ff;
   logic [RPM_W-1:0]         rpm5_ff [NUM_WHEELS];
   logic [RPM_W-1:0]         max01_ff, max23_ff, max01_in, max23_in;
   logic                     scaled5_ff, scaled5_in;

   logic [RPM_W-1:0]         den6_ff, den6_in;
   logic [N_W-1:0]           num6_ff [NUM_WHEELS];
   logic [N_W-1:0]           num6_in [NUM_WHEELS];
   logic [LIM_W-1:0]         keep6_ff [NUM_WHEELS];
   logic [LIM_W-1:0]         keep6_in [NUM_WHEELS];
   side_type                 side6_ff, side6_in;

   logic signed [OUT_W-1:0]  rpm_out [NUM_WHEELS];

   assign en6       = !v6_ff || div_ready;
   assign en5       = !v5_ff || en6;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1;

   always_comb begin
      x1_in = clamp_cmd(req_sideways_speed, side_lim_ff);
      y1_in = clamp_cmd(req_forward_speed, fwd_lim_ff);
      w1_in = clamp_cmd(req_turn_rate, turn_lim_ff);
   end

   always_comb begin
      a2_in  = -MIX_W'(x1_ff) - MIX_W'(y1_ff);
      b2_in  = MIX_W'(y1_ff) - MIX_W'(x1_ff);
      tf2_in = TURN_W'(w1_ff) * TURN_W'($signed({1'b0, front_ratio_ff}));
      tb2_in = TURN_W'(w1_ff) * TURN_W'($signed({1'b0, back_ratio_ff}));
   end

   // wheel sums: 0 and 1 take the front turn term, 2 and 3 the back
   always_comb begin
      mix3[0]  = a2_ff;
      mix3[1]  = b2_ff;
      mix3[2]  = -a2_ff;
      mix3[3]  = -b2_ff;
      turn3[0] = tf2_ff;
      turn3[1] = tf2_ff;
      turn3[2] = tb2_ff;
      turn3[3] = tb2_ff;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         s3[i]      = (SUM_W'(mix3[i]) <<< COEF_FRAC_BITS) + SUM_W'(turn3[i]);
         neg3_in[i] = s3[i][SUM_W-1];
         mag3_in[i] = neg3_in[i] ? SUM_W'(-s3[i]) : SUM_W'(s3[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         prod4[i]   = PROD_W'(mag3_ff[i]) * PROD_W'(rpm_ratio_ff);
         rpm4_in[i] = prod4[i][2*COEF_FRAC_BITS +: RPM_W];
      end
   end

   always_comb begin
      max01_in   = (rpm4_ff[0] > rpm4_ff[1]) ? rpm4_ff[0] : rpm4_ff[1];
      max23_in   = (rpm4_ff[2] > rpm4_ff[3]) ? rpm4_ff[2] : rpm4_ff[3];
      scaled5_in = 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         scaled5_in = scaled5_in | (rpm4_ff[i] > RPM_W'(rpm_lim_ff));
      end
   end

   always_comb begin
      den6_in         = (max01_ff > max23_ff) ? max01_ff : max23_ff;
      side6_in.neg    = neg5_ff;
      side6_in.scaled = scaled5_ff;
      for (int i = 0; i < NUM_WHEELS; i++) begin
         num6_in[i]  = N_W'(rpm5_ff[i]) * N_W'(rpm_lim_ff);
         keep6_in[i] = rpm5_ff[i][LIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         x1_ff <= x1_in;
         y1_ff <= y1_in;
         w1_ff <= w1_in;
      end
      if (en2) begin
         a2_ff  <= a2_in;
         b2_ff  <= b2_in;
         tf2_ff <= tf2_in;
         tb2_ff <= tb2_in;
      end
      if (en3) begin
         neg3_ff <= neg3_in;
         mag3_ff <= mag3_in;
      end
      if (en4) begin
         neg4_ff <= neg3_ff;
         rpm4_ff <= rpm4_in;
      end
      if (en5) begin
         neg5_ff    <= neg4_ff;
         rpm5_ff    <= rpm4_ff;
         max01_ff   <= max01_in;
         max23_ff   <= max23_in;
         scaled5_ff <= scaled5_in;
      end
      if (en6) begin
         den6_ff  <= den6_in;
         num6_ff  <= num6_in;
         keep6_ff <= keep6_in;
         side6_ff <= side6_in;
      end
   end

   mwsm_scale_div #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_scale_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v6_ff),
      .in_ready   (div_ready),
      .in_num     (num6_ff),
      .in_den     (den6_ff),
      .in_keep    (keep6_ff),
      .in_side    (side6_ff),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_rpm    (rpm_out),
      .out_scaled (rsp_was_scaled)
   );

   assign rsp_wheel0_rpm = rpm_out[0];
   assign rsp_wheel1_rpm = rpm_out[1];
   assign rsp_wheel2_rpm = rpm_out[2];
   assign rsp_wheel3_rpm = rpm_out[3];

endmodule

@@ hdl/mwsm_scale_div.sv @@
module mwsm_scale_div import mwsm_pkg::*; #(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [rpm_width(COEF_FRAC_BITS)+LIM_W-1:0] in_num [NUM_WHEELS],
   input  logic [rpm_width(COEF_FRAC_BITS)-1:0]       in_den,
   input  logic [LIM_W-1:0]        in_keep [NUM_WHEELS],
   input  side_type                in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [OUT_W-1:0] out_rpm [NUM_WHEELS],
   output logic                    out_scaled
);

   localparam int RPM_W  = rpm_width(COEF_FRAC_BITS);
   localparam int N_W    = RPM_W + LIM_W;
   localparam int STAGES = LIM_W;

   logic [STAGES-1:0] v_ff;
   logic [STAGES:0]   en;
   logic [N_W-1:0]    rem_ff  [STAGES][NUM_WHEELS];
   logic [LIM_W-1:0]  q_ff    [STAGES][NUM_WHEELS];
   logic [LIM_W-1:0]  keep_ff [STAGES][NUM_WHEELS];
   logic [RPM_W-1:0]  den_ff  [STAGES];
   side_type          side_ff [STAGES];

   logic                    out_valid_ff;
   logic signed [OUT_W-1:0] out_rpm_ff [NUM_WHEELS];
   logic                    out_scaled_ff;
   logic signed [OUT_W-1:0] out_rpm_in [NUM_WHEELS];
   logic [LIM_W-1:0]        res_mag [NUM_WHEELS];

   always_comb begin
      en[STAGES] = !out_valid_ff || out_ready;
      for (int k = STAGES - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready = en[0];

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int BIT = STAGES - 1 - k;

      logic             v_prev;
      logic [N_W-1:0]   rem_prev  [NUM_WHEELS];
      logic [LIM_W-1:0] q_prev    [NUM_WHEELS];
      logic [LIM_W-1:0] keep_prev [NUM_WHEELS];
      logic [RPM_W-1:0] den_prev;
      side_type         side_prev;
      logic [N_W-1:0]   den_shift;
      logic [N_W-1:0]   rem_in    [NUM_WHEELS];
      logic [LIM_W-1:0] q_in      [NUM_WHEELS];

      if (k == 0) begin : g_first
         always_comb begin
            v_prev    = in_valid;
            den_prev  = in_den;
            side_prev = in_side;
            for (int i = 0; i < NUM_WHEELS; i++) begin
               rem_prev[i]  = in_num[i];
               q_prev[i]    = '0;
               keep_prev[i] = in_keep[i];
            end
         end
      end else begin : g_next
         always_comb begin
            v_prev    = v_ff[k-1];
            den_prev  = den_ff[k-1];
            side_prev = side_ff[k-1];
            for (int i = 0; i < NUM_WHEELS; i++) begin
               rem_prev[i]  = rem_ff[k-1][i];
               q_prev[i]    = q_ff[k-1][i];
               keep_prev[i] = keep_ff[k-1][i];
            end
         end
      end

      always_comb begin
         den_shift = N_W'(den_prev) << BIT;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            if (rem_prev[i] >= den_shift) begin
               rem_in[i] = rem_prev[i] - den_shift;
               q_in[i]   = {q_prev[i][LIM_W-2:0], 1'b1};
            end else begin
               rem_in[i] = rem_prev[i];
               q_in[i]   = {q_prev[i][LIM_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
            for (int i = 0; i < NUM_WHEELS; i++) begin
               rem_ff[k][i]  <= rem_in[i];
               q_ff[k][i]    <= q_in[i];
               keep_ff[k][i] <= keep_prev[i];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
         res_mag[i] = side_ff[STAGES-1].scaled ? q_ff[STAGES-1][i] : keep_ff[STAGES-1][i];
         if (side_ff[STAGES-1].neg[i]) begin
            out_rpm_in[i] = -$signed({1'b0, res_mag[i]});
         end else begin
            out_rpm_in[i] = $signed({1'b0, res_mag[i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en[STAGES]) begin
         out_valid_ff <= v_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[STAGES]) begin
         out_rpm_ff    <= out_rpm_in;
         out_scaled_ff <= side_ff[STAGES-1].scaled;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_rpm    = out_rpm_ff;
   assign out_scaled = out_scaled_ff;

endmodule

@@ hdl/mwsm_checker.sv @@
module mwsm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_wheel0_rpm,
   input logic signed [15:0] rsp_wheel1_rpm,
   input logic signed [15:0] rsp_wheel2_rpm,
   input logic signed [15:0] rsp_wheel3_rpm,
   input logic               rsp_was_scaled
);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_backpressure_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused while the output side is free");

   a_no_min_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wheel0_rpm != 16'sh8000 && rsp_wheel1_rpm != 16'sh8000 &&
                    rsp_wheel2_rpm != 16'sh8000 && rsp_wheel3_rpm != 16'sh8000)
      else $error("wheel rpm outside the limited range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_wheel0_rpm) &&
         $stable(rsp_wheel1_rpm) && $stable(rsp_wheel2_rpm) &&
         $stable(rsp_wheel3_rpm) && $stable(rsp_was_scaled))
      else $error("stalled result changed");

endmodule

bind mecanum_wheel_speed_mixer_core mwsm_checker u_checker (.*);
